[hw/rtl/mfd_pkg.sv]
// shared constants and types for the meter frame decoder
`default_nettype none

package mfd_pkg;

  localparam int unsigned WIN_DEPTH   = 7;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned MAG_W       = 19;
  localparam int unsigned READING_W   = 20;

  localparam logic [7:0] FRAME_HEAD   = 8'hFE;
  localparam logic [7:0] FRAME_TAIL   = 8'hFF;
  localparam logic [7:0] SIGN_NIBBLE  = 8'hF0;
  localparam logic [7:0] LOW_NIBBLE   = 8'h0F;

  localparam logic [13:0] WEIGHT_E4   = 14'd10000;
  localparam logic [9:0]  WEIGHT_E3   = 10'd1000;
  localparam logic [6:0]  WEIGHT_E2   = 7'd100;
  localparam logic [3:0]  WEIGHT_E1   = 4'd10;

  localparam int signed READING_MIN   = -433305;
  localparam int signed READING_MAX   = 433305;

  typedef logic [BYTE_W-1:0] byte_t;

  // frame bytes 1 to 5 as captured in the input register
  typedef struct packed {
    byte_t b1;
    byte_t b2;
    byte_t b3;
    byte_t b4;
    byte_t b5;
  } frame_digits_t;

endpackage

`default_nettype wire

[hw/rtl/meter_frame_decoder.sv]
// meter frame decoder: byte window, frame match and signed reading
// an accepted closing byte passes through the input register, then the result register, to out_valid
// throughput: one byte per cycle while no frame result is stalled, set by the input register and result register
// a result stalled on out_ready holds the input register; bytes with no frame never stall
// reset (rst_n low, synchronous) clears the byte window and both valid flags
`default_nettype none

module meter_frame_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [19:0]      out_reading
);

  mfd_pkg::byte_t           window_r [mfd_pkg::WIN_DEPTH];
  logic                     s1_valid_r;
  logic                     s1_match_r;
  mfd_pkg::frame_digits_t   s1_digits_r;
  logic                     out_valid_r;
  logic [19:0]              out_reading_r;

  logic                     in_fire;
  logic                     out_free;
  logic                     s1_go;
  logic                     s1_emit;
  logic                     match_nxt;
  logic [mfd_pkg::MAG_W-1:0] mag;
  logic [19:0]              reading_nxt;
  logic                     neg;

  assign out_free  = !out_valid_r || out_ready;
  assign s1_go     = s1_valid_r && (!s1_match_r || out_free);
  assign s1_emit   = s1_go && s1_match_r;
  assign in_ready  = !s1_valid_r || s1_go;
  assign in_fire   = in_valid && in_ready;
  assign match_nxt = (window_r[0] == mfd_pkg::FRAME_HEAD) &&
                     (in_rx_byte == mfd_pkg::FRAME_TAIL);

  // window shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mfd_pkg::WIN_DEPTH; i++) begin
        window_r[i] <= '0;
      end
    end else if (in_fire) begin
      for (int i = 0; i < mfd_pkg::WIN_DEPTH - 1; i++) begin
        window_r[i] <= window_r[i+1];
      end
      window_r[mfd_pkg::WIN_DEPTH-1] <= in_rx_byte;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_match_r     <= match_nxt;
      s1_digits_r.b1 <= window_r[1];
      s1_digits_r.b2 <= window_r[2];
      s1_digits_r.b3 <= window_r[3];
      s1_digits_r.b4 <= window_r[4];
      s1_digits_r.b5 <= window_r[5];
    end
  end

  function automatic logic [mfd_pkg::MAG_W-1:0] MAG_SUM(input mfd_pkg::frame_digits_t d);
    logic [mfd_pkg::MAG_W-1:0] t1;
    logic [mfd_pkg::MAG_W-1:0] t2;
    logic [mfd_pkg::MAG_W-1:0] t3;
    logic [mfd_pkg::MAG_W-1:0] t4;
    logic [mfd_pkg::MAG_W-1:0] t5;
    t1 = mfd_pkg::MAG_W'(d.b1 & mfd_pkg::LOW_NIBBLE) * mfd_pkg::MAG_W'(mfd_pkg::WEIGHT_E4);
    t2 = mfd_pkg::MAG_W'(d.b2) * mfd_pkg::MAG_W'(mfd_pkg::WEIGHT_E3);
    t3 = mfd_pkg::MAG_W'(d.b3) * mfd_pkg::MAG_W'(mfd_pkg::WEIGHT_E2);
    t4 = mfd_pkg::MAG_W'(d.b4) * mfd_pkg::MAG_W'(mfd_pkg::WEIGHT_E1);
    t5 = mfd_pkg::MAG_W'(d.b5);
    return t1 + t2 + t3 + t4 + t5;
  endfunction

  // weighted digit sum and sign
  always_comb begin
    mag = MAG_SUM(s1_digits_r);
    neg = |(s1_digits_r.b1 & mfd_pkg::SIGN_NIBBLE);
    reading_nxt = neg ? (20'd0 - 20'(mag)) : 20'(mag);
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_emit) begin
      out_reading_r <= reading_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_reading = out_reading_r;

endmodule

`default_nettype wire

[hw/rtl/mfd_checker.sv]
// port checker for the meter frame decoder and its bind
`default_nettype none

module mfd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [7:0]  in_rx_byte,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [19:0] out_reading
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_reading))
    else $error("result beat changed while stalled");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // reading stays inside the decodable range
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_reading) >= 20'(mfd_pkg::READING_MIN)) &&
                  ($signed(out_reading) <= 20'(mfd_pkg::READING_MAX)))
    else $error("reading out of range");

  // a fresh result follows an accepted closing byte
  a_rise_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |->
      $past(in_valid && in_ready && (in_rx_byte == mfd_pkg::FRAME_TAIL), 2))
    else $error("result without closing byte");

endmodule

bind meter_frame_decoder mfd_checker u_mfd_checker (.*);

`default_nettype wire

[bench/reading_checker.sv]
// checker for the meter frame decoder: predicts each reading from the byte stream and compares
module reading_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [19:0] out_reading,
  output int          mismatch_count,
  output int          readings_pending,
  output int          readings_checked
);

  mfd_pkg::byte_t recent_bytes [mfd_pkg::WIN_DEPTH];
  logic [19:0]    expected_readings [$];
  logic [19:0]    oldest_reading;
  int             mismatches;
  int             checked;
  int             pending;

  assign mismatch_count   = mismatches;
  assign readings_pending = pending;
  assign readings_checked = checked;

  function automatic logic [19:0] frame_reading(input mfd_pkg::byte_t lead,
                                                input mfd_pkg::byte_t d2,
                                                input mfd_pkg::byte_t d3,
                                                input mfd_pkg::byte_t d4,
                                                input mfd_pkg::byte_t d5);
    int magnitude;
    magnitude = int'(lead & mfd_pkg::LOW_NIBBLE) * int'(mfd_pkg::WEIGHT_E4)
              + int'(d2) * int'(mfd_pkg::WEIGHT_E3)
              + int'(d3) * int'(mfd_pkg::WEIGHT_E2)
              + int'(d4) * int'(mfd_pkg::WEIGHT_E1) + int'(d5);
    if ((lead & mfd_pkg::SIGN_NIBBLE) != 8'h00)
      magnitude = -magnitude;
    return magnitude[19:0];
  endfunction

  initial begin
    mismatches = 0;
    checked    = 0;
    pending    = 0;
    foreach (recent_bytes[k])
      recent_bytes[k] = '0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (recent_bytes[k])
        recent_bytes[k] = '0;
      expected_readings.delete();
    end else begin
      // result beat first: its expectation was queued by an earlier accepted closing byte
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          $error("reading: expected none, actual %0d", $signed(out_reading));
          mismatches++;
        end else begin
          oldest_reading = expected_readings.pop_front();
          if (out_reading !== oldest_reading) begin
            $error("reading: expected %0d, actual %0d",
                   $signed(oldest_reading), $signed(out_reading));
            mismatches++;
          end
          checked++;
        end
      end
      if (in_valid && in_ready) begin
        if (recent_bytes[0] == mfd_pkg::FRAME_HEAD && in_rx_byte == mfd_pkg::FRAME_TAIL)
          expected_readings.push_back(frame_reading(recent_bytes[1], recent_bytes[2],
                                                    recent_bytes[3], recent_bytes[4],
                                                    recent_bytes[5]));
        for (int k = 0; k < mfd_pkg::WIN_DEPTH - 1; k++)
          recent_bytes[k] = recent_bytes[k + 1];
        recent_bytes[mfd_pkg::WIN_DEPTH - 1] = in_rx_byte;
      end
    end
    pending = expected_readings.size();
  end

endmodule

[bench/tb_meter_frame_decoder.sv]
// testbench top for the meter frame decoder: byte stimulus, result back-pressure and verdict
module tb_meter_frame_decoder;

  typedef enum int {CHUNK_FRAME, CHUNK_DOUBLE, CHUNK_BROKEN, CHUNK_NOISE} chunk_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [19:0] out_reading;

  int             mismatch_count;
  int             readings_pending;
  int             readings_checked;
  int             bytes_sent;
  bit             idle_en;
  bit             hold_req;
  int             hold_left;
  mfd_pkg::byte_t byte_plan [$];

  meter_frame_decoder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_reading(out_reading)
  );

  reading_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_reading     (out_reading),
    .mismatch_count  (mismatch_count),
    .readings_pending(readings_pending),
    .readings_checked(readings_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic mfd_pkg::byte_t digit_byte();
    unique case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return mfd_pkg::byte_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic mfd_pkg::byte_t noise_byte();
    unique case ($urandom_range(0, 4))
      0: return mfd_pkg::FRAME_HEAD;
      1: return mfd_pkg::FRAME_TAIL;
      default: return mfd_pkg::byte_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void push_frame_body();
    byte_plan.push_back(mfd_pkg::byte_t'($urandom_range(0, 255)));
    repeat (4) byte_plan.push_back(digit_byte());
    byte_plan.push_back(noise_byte());
  endfunction

  function automatic void plan_chunk(input chunk_t kind);
    unique case (kind)
      CHUNK_FRAME: begin
        byte_plan.push_back(mfd_pkg::FRAME_HEAD);
        push_frame_body();
        byte_plan.push_back(mfd_pkg::FRAME_TAIL);
      end
      CHUNK_DOUBLE: begin
        // two frames one byte apart
        byte_plan.push_back(mfd_pkg::FRAME_HEAD);
        byte_plan.push_back(mfd_pkg::FRAME_HEAD);
        repeat (5) byte_plan.push_back(digit_byte());
        byte_plan.push_back(mfd_pkg::FRAME_TAIL);
        byte_plan.push_back(mfd_pkg::FRAME_TAIL);
      end
      CHUNK_BROKEN: begin
        byte_plan.push_back(mfd_pkg::FRAME_HEAD);
        if ($urandom_range(0, 1)) begin
          push_frame_body();
          byte_plan.push_back(mfd_pkg::byte_t'($urandom_range(0, 254)));
        end else begin
          repeat ($urandom_range(1, 5)) byte_plan.push_back(digit_byte());
        end
      end
      default: repeat ($urandom_range(1, 6)) byte_plan.push_back(noise_byte());
    endcase
  endfunction

  function automatic void plan_random(input int count);
    int pick;
    while (byte_plan.size() < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 55)      plan_chunk(CHUNK_FRAME);
      else if (pick < 65) plan_chunk(CHUNK_DOUBLE);
      else if (pick < 80) plan_chunk(CHUNK_BROKEN);
      else                plan_chunk(CHUNK_NOISE);
    end
  endfunction

  task automatic send_byte(input mfd_pkg::byte_t value);
    @(negedge clk);
    while (idle_en && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_plan();
    while (byte_plan.size() > 0)
      send_byte(byte_plan.pop_front());
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    wait (readings_pending == 0);
    repeat (4) @(posedge clk);
  endtask

  // result side: random idling plus an occasional long hold-off
  initial begin
    out_ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = 150;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(idle_en && $urandom_range(0, 99) < 10);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d readings outstanding", readings_pending);
    $display("meter_frame_decoder: mismatch");
    $finish;
  end

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_rx_byte = 8'h00;
    idle_en    = 1'b1;
    hold_req   = 1'b0;
    bytes_sent = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // startup tails, max positive, overlapping frames with negative zero, max negative
    byte_plan = '{8'hFF, 8'hFF,
                  8'hFE, 8'h0F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF,
                  8'hFE, 8'hFE, 8'hF0, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF,
                  8'hFE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h55, 8'hFF};
    send_plan();

    plan_random(180);
    send_plan();
    drain();

    // back-to-back frames against a stalled receiver
    idle_en  = 1'b0;
    hold_req = 1'b1;
    repeat (8) plan_chunk(CHUNK_FRAME);
    send_plan();
    drain();

    plan_random(120);
    send_plan();

    idle_en = 1'b1;
    plan_random(190);
    send_plan();
    drain();

    $display("sent %0d bytes, checked %0d readings", bytes_sent, readings_checked);
    $display("covered extremes, overlapping and broken frames, long output stall and drains");
    if (mismatch_count == 0)
      $display("meter_frame_decoder: match");
    else
      $display("meter_frame_decoder: mismatch");
    $finish;
  end

endmodule
